// ===== sv/hbtb_pkg.sv =====
// Shared types, constants and helpers for the heat budget token bucket.
// No dependencies; every other file of the block imports this package.
package hbtb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int AMT_SH      = FRAC_BITS - 8;
    localparam int TOL_LSB     = 66;
    localparam int DIVISOR     = 1000;
    localparam int REM_W       = 10;
    localparam int PROD_W      = 56;
    localparam int PP_W        = 40;
    localparam int DIV_W       = 48 + FRAC_BITS;
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYC     = (DIV_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_PAD_W   = DIV_CYC * DIV_BITS;
    localparam int DIV_CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int S_TDATA_W   = 112;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [2:0] {
        KIND_RAW     = 3'd0,
        KIND_RESERVE = 3'd1,
        KIND_CONSUME = 3'd2,
        KIND_QUERY   = 3'd3,
        KIND_RESET   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_ADVANCE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_lo;
        logic mul_hi;
        logic div_load;
        logic div_step;
        logic advance;
        logic finish;
        logic sel_req;
    } cmd_t;

    typedef struct packed {
        logic need_rec;
        logic need_req;
        logic div_last;
        logic out_free;
    } status_t;

    // Whole units to fixed point, saturated to 32 bits.
    function automatic logic [31:0] to_fixed(input logic [15:0] whole);
        logic [47:0] v;
        v = 48'(whole) << FRAC_BITS;
        return (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

// ===== sv/hbtb_div.sv =====
// Iterative divide by the constant 1000, several quotient bits per cycle.
// Depends on hbtb_pkg.
module hbtb_div
    import hbtb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             step,
    input  logic [DIV_W-1:0] dividend,
    output logic [DIV_W-1:0] quotient,
    output logic             last
);

    logic [DIV_PAD_W-1:0] acc_reg, acc_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;

    always_comb begin
        logic [REM_W:0]       r;
        logic [DIV_PAD_W-1:0] a;
        logic                 ge;
        r = {1'b0, rem_reg};
        a = acc_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            r  = {r[REM_W-1:0], a[DIV_PAD_W-1]};
            ge = (r >= (REM_W+1)'(DIVISOR));
            a  = {a[DIV_PAD_W-2:0], ge};
            if (ge) begin
                r = r - (REM_W+1)'(DIVISOR);
            end
        end
        acc_next = a;
        rem_next = r[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= DIV_CNT_W'(DIV_CYC - 1);
        end else if (step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg <= DIV_PAD_W'(dividend);
            rem_reg <= '0;
        end else if (step) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = acc_reg[DIV_W-1:0];
    assign last     = (cnt_reg == '0);

endmodule

// ===== sv/hbtb_datapath.sv =====
// Datapath: bucket state, item capture, shared multiplier, divide unit and
// result register. Depends on hbtb_pkg and hbtb_div.
module hbtb_datapath
    import hbtb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [2:0]           in_kind,
    input  logic [31:0]          in_now_ms,
    input  logic [15:0]          in_reported_heat,
    input  logic [15:0]          in_cooling_rate,
    input  logic [15:0]          in_heat_limit,
    input  logic                 in_heat_fresh,
    input  logic [23:0]          in_amount,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [2:0]  kind_reg;
    logic [31:0] now_reg;
    logic [15:0] rest_reg;
    logic [15:0] rate_in_reg;
    logic [15:0] lim_reg;
    logic        fresh_reg;
    logic [23:0] amount_reg;
    logic [31:0] dt_reg;
    logic        gt_reg;

    logic [31:0] budget_reg, budget_next;
    logic [15:0] recovery_rate_reg, recovery_rate_next;
    logic [15:0] budget_cap_reg, budget_cap_next;
    logic [31:0] last_time_reg, last_time_next;
    logic        primed_reg, primed_next;
    logic        grant_next;

    logic [PP_W-1:0] pp_lo_reg, pp_hi_reg;
    logic            m_valid_reg;
    logic [31:0]     out_rest_reg;
    logic            out_grant_reg;
    logic            out_ready_reg;

    logic [32:0]       diff;
    logic [23:0]       mul_a;
    logic [15:0]       mul_b;
    logic [PP_W-1:0]   mul_p;
    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  quot;
    logic              div_last;
    logic [31:0]       cap_fix;
    logic [31:0]       rec_sat;
    logic [32:0]       rec_sum;
    logic              is_adv_kind;

    assign diff = {1'b0, in_now_ms} - {1'b0, last_time_reg};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg    <= in_kind;
            now_reg     <= in_now_ms;
            rest_reg    <= in_reported_heat;
            rate_in_reg <= in_cooling_rate;
            lim_reg     <= in_heat_limit;
            fresh_reg   <= in_heat_fresh;
            amount_reg  <= in_amount;
            dt_reg      <= diff[31:0];
            gt_reg      <= !diff[32] && (diff[31:0] != 32'd0);
        end
    end

    assign mul_a = cmd.sel_req ? amount_reg : 24'(recovery_rate_reg);
    assign mul_b = cmd.mul_hi ? dt_reg[31:16] : dt_reg[15:0];
    assign mul_p = PP_W'(mul_a) * PP_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            pp_lo_reg <= mul_p;
        end
        if (cmd.mul_hi) begin
            pp_hi_reg <= mul_p;
        end
    end

    assign prod     = PROD_W'(pp_lo_reg) + (PROD_W'(pp_hi_reg) << 16);
    assign dividend = cmd.sel_req ? (DIV_W'(prod) << AMT_SH)
                                  : (DIV_W'(prod[47:0]) << FRAC_BITS);

    hbtb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (dividend),
        .quotient (quot),
        .last     (div_last)
    );

    assign cap_fix = to_fixed(budget_cap_reg);
    assign rec_sat = (quot > DIV_W'(cap_fix)) ? cap_fix : quot[31:0];
    assign rec_sum = {1'b0, budget_reg} + {1'b0, rec_sat};

    assign is_adv_kind = (kind_reg == KIND_RAW) || (kind_reg == KIND_RESERVE)
                      || (kind_reg == KIND_CONSUME) || (kind_reg == KIND_QUERY);

    assign status.need_rec = primed_reg && gt_reg && is_adv_kind;
    assign status.need_req = primed_reg && gt_reg && (kind_reg == KIND_CONSUME)
                          && (amount_reg != 24'd0);
    assign status.div_last = div_last;
    assign status.out_free = !m_valid_reg || m_tready;

    always_comb begin
        logic [15:0]      r_clamp;
        logic [31:0]      r_fix;
        logic [31:0]      lim_fix;
        logic [31:0]      b;
        logic [DIV_W-1:0] req;
        logic             deny;
        logic [31:0]      b_spent;
        r_clamp = (rest_reg > lim_reg) ? lim_reg : rest_reg;
        r_fix   = to_fixed(r_clamp);
        lim_fix = to_fixed(lim_reg);
        req     = (kind_reg == KIND_RESERVE) ? (DIV_W'(amount_reg) << AMT_SH) : quot;
        deny    = (DIV_W'(budget_reg) + DIV_W'(TOL_LSB)) < req;
        b_spent = (DIV_W'(budget_reg) >= req) ? (budget_reg - req[31:0]) : 32'd0;
        b       = budget_reg;

        budget_next        = budget_reg;
        recovery_rate_next = recovery_rate_reg;
        budget_cap_next    = budget_cap_reg;
        last_time_next     = last_time_reg;
        primed_next        = primed_reg;
        grant_next         = 1'b0;

        unique case (kind_reg)
            KIND_RAW: begin
                if (!primed_reg) begin
                    budget_next        = r_fix;
                    recovery_rate_next = rate_in_reg;
                    budget_cap_next    = lim_reg;
                    last_time_next     = now_reg;
                    primed_next        = 1'b1;
                end else begin
                    if (fresh_reg && b > r_fix) begin
                        b = r_fix;
                    end
                    if (b > lim_fix) begin
                        b = lim_fix;
                    end
                    budget_next        = b;
                    recovery_rate_next = rate_in_reg;
                    budget_cap_next    = lim_reg;
                end
            end
            KIND_RESERVE: begin
                if (!primed_reg) begin
                    last_time_next = now_reg;
                end
                if (amount_reg == 24'd0) begin
                    grant_next = 1'b1;
                end else if (!deny) begin
                    grant_next  = 1'b1;
                    budget_next = b_spent;
                end
            end
            KIND_CONSUME: begin
                if (!primed_reg) begin
                    grant_next = 1'b0;
                end else if (!gt_reg || amount_reg == 24'd0) begin
                    grant_next = (budget_reg != 32'd0);
                end else if (deny) begin
                    budget_next = 32'd0;
                end else begin
                    grant_next  = 1'b1;
                    budget_next = b_spent;
                end
            end
            KIND_QUERY: begin
                if (!primed_reg) begin
                    last_time_next = now_reg;
                end
            end
            KIND_RESET: begin
                budget_next        = r_fix;
                recovery_rate_next = rate_in_reg;
                budget_cap_next    = lim_reg;
                last_time_next     = now_reg;
                primed_next        = 1'b1;
            end
            default: begin
                grant_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg        <= '0;
            recovery_rate_reg <= '0;
            budget_cap_reg    <= '0;
            last_time_reg     <= '0;
            primed_reg        <= 1'b0;
        end else if (cmd.advance) begin
            budget_reg    <= (rec_sum > {1'b0, cap_fix}) ? cap_fix : rec_sum[31:0];
            last_time_reg <= now_reg;
        end else if (cmd.finish) begin
            budget_reg        <= budget_next;
            recovery_rate_reg <= recovery_rate_next;
            budget_cap_reg    <= budget_cap_next;
            last_time_reg     <= last_time_next;
            primed_reg        <= primed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_rest_reg  <= budget_next;
            out_grant_reg <= grant_next;
            out_ready_reg <= primed_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_ready_reg, out_grant_reg, out_rest_reg};

endmodule

// ===== sv/hbtb_ctrl.sv =====
// Controller: sequences capture, multiply, divide, advance and finish.
// Depends on hbtb_pkg.
module hbtb_ctrl
    import hbtb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.sel_req = sel_reg;
        s_tready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                sel_next   = 1'b0;
                state_next = status.need_rec ? ST_MUL_LO : ST_FINISH;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = sel_reg ? ST_FINISH : ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                if (status.need_req) begin
                    sel_next   = 1'b1;
                    state_next = ST_MUL_LO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/heat_budget_token_bucket_top.sv =====
// Top level of the heat budget token bucket: controller plus datapath.
// Depends on hbtb_pkg, hbtb_ctrl and hbtb_datapath.
//
// Usage:
//   Each input transaction is one event (raw update, reserve, consume,
//   query, reset) and yields exactly one result transaction carrying the
//   predicted remaining heat in Q16.16, the grant flag and the primed flag.
//   One event is in work at a time. With no recovery due an event goes from
//   accept through the check step to finish; when the budget is advanced over
//   elapsed time it also passes the multiply steps, divider load and run and
//   the advance step, and a consume that also computes the required heat
//   multiplies and divides once more. The divide-by-1000 unit gives 8 quotient
//   bits per cycle and the shared 24x16 multiplier is used twice per product.
//   The result register lets the next event be accepted while a result
//   waits; if the receiver stalls, the next event holds in its last step
//   until the result register frees up.
//   Synchronous reset clears the bucket to zero and unprimed, and empties
//   the result register; s_tready is high in the first cycle after reset.
module heat_budget_token_bucket_top
    import hbtb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // now_ms[31:0], reported_heat[47:32], cooling_rate[63:48],
    // heat_limit[79:64], heat_fresh[80], amount[104:81], zero[111:105]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rest_heat[31:0], granted[32], ready_res[33], zero[39:34]
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    hbtb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hbtb_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_kind          (s_tuser[2:0]),
        .in_now_ms        (s_tdata[31:0]),
        .in_reported_heat (s_tdata[47:32]),
        .in_cooling_rate  (s_tdata[63:48]),
        .in_heat_limit    (s_tdata[79:64]),
        .in_heat_fresh    (s_tdata[80]),
        .in_amount        (s_tdata[104:81]),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_tdata          (m_tdata)
    );

endmodule

// ===== sv/hbtb_checker.sv =====
// Port-level checks of the heat budget token bucket, bound to the top level.
// Depends on hbtb_pkg and heat_budget_token_bucket_top.
module hbtb_checker
    import hbtb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic seen_primed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_primed_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[33]) begin
            seen_primed_reg <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction accepted while previous one in work");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_primed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_primed_reg |-> m_tdata[33])
        else $error("ready flag dropped without reset");

endmodule

bind heat_budget_token_bucket_top hbtb_checker u_hbtb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/heat_budget_checker.sv =====
// Watches both stream channels of the heat budget token bucket, predicts each result
// from the accepted events and compares field by field. Depends on hbtb_pkg.
`timescale 1ns / 100ps

module heat_budget_checker
    import hbtb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // now_ms, reported_heat, cooling_rate, heat_limit, heat_fresh, amount, zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // rest_heat, granted, ready_res, zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [31:0] rest_heat;
        logic        granted;
        logic        ready_res;
    } heat_result_t;

    logic [31:0]  bucket;
    logic [15:0]  refill_rate;
    logic [15:0]  bucket_cap;
    logic [31:0]  last_ms;
    logic         primed;
    heat_result_t heat_results_q[$];

    function automatic logic [63:0] fixed_of(input logic [15:0] whole);
        logic [63:0] v;
        v = 64'(whole) << FRAC_BITS;
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    // floor(p * 2^sh / 1000), split so the shift cannot overflow
    function automatic logic [63:0] per_ms_scaled(input logic [63:0] p, input int sh);
        return ((p / 64'(DIVISOR)) << sh) + (((p % 64'(DIVISOR)) << sh) / 64'(DIVISOR));
    endfunction

    task automatic refill(input logic [31:0] t);
        logic [63:0] cap;
        logic [63:0] gain;
        logic [63:0] sum;
        if (!primed) begin
            last_ms = t;
        end else if (t > last_ms) begin
            cap  = fixed_of(bucket_cap);
            gain = per_ms_scaled(64'(refill_rate) * 64'(t - last_ms), FRAC_BITS);
            if (gain > cap) gain = cap;
            sum    = 64'(bucket) + gain;
            bucket = (sum > cap) ? cap[31:0] : sum[31:0];
            last_ms = t;
        end
    endtask

    task automatic load_bucket(input logic [15:0] rest, input logic [15:0] rate,
                               input logic [15:0] lim, input logic [31:0] t);
        logic [15:0] level;
        level       = (rest > lim) ? lim : rest;
        bucket      = 32'(fixed_of(level));
        refill_rate = rate;
        bucket_cap  = lim;
        last_ms     = t;
        primed      = 1'b1;
    endtask

    task automatic draw(input logic [63:0] need, input logic empty_on_deny, output logic ok);
        if (64'(bucket) + 64'(TOL_LSB) < need) begin
            if (empty_on_deny) bucket = '0;
            ok = 1'b0;
        end else begin
            bucket = (64'(bucket) >= need) ? bucket - need[31:0] : '0;
            ok = 1'b1;
        end
    endtask

    task automatic step_budget(input logic [2:0] kind, input logic [S_TDATA_W-1:0] d,
                               output heat_result_t res);
        logic [31:0] now;
        logic [15:0] rest;
        logic [15:0] rate;
        logic [15:0] lim;
        logic [15:0] level;
        logic        fresh;
        logic [23:0] amt;
        logic [31:0] dt;
        logic        ok;
        now   = d[31:0];
        rest  = d[47:32];
        rate  = d[63:48];
        lim   = d[79:64];
        fresh = d[80];
        amt   = d[104:81];
        ok    = 1'b0;
        case (kind)
            KIND_RAW: begin
                if (!primed) begin
                    load_bucket(rest, rate, lim, now);
                end else begin
                    level = (rest > lim) ? lim : rest;
                    refill(now);
                    refill_rate = rate;
                    bucket_cap  = lim;
                    if (fresh && 64'(bucket) > fixed_of(level)) bucket = 32'(fixed_of(level));
                    if (64'(bucket) > fixed_of(bucket_cap)) bucket = 32'(fixed_of(bucket_cap));
                end
            end
            KIND_RESERVE: begin
                refill(now);
                if (amt == '0) ok = 1'b1;
                else draw(64'(amt) << AMT_SH, 1'b0, ok);
            end
            KIND_CONSUME: begin
                if (!primed) begin
                    ok = 1'b0;
                end else if (now <= last_ms) begin
                    ok = (bucket != '0);
                end else begin
                    dt = now - last_ms;
                    refill(now);
                    if (amt == '0) ok = (bucket != '0);
                    else draw(per_ms_scaled(64'(amt) * 64'(dt), AMT_SH), 1'b1, ok);
                end
            end
            KIND_QUERY: refill(now);
            KIND_RESET: load_bucket(rest, rate, lim, now);
            default: ;
        endcase
        res.rest_heat = bucket;
        res.granted   = ok;
        res.ready_res = primed;
    endtask

    always @(posedge aclk) begin
        heat_result_t want;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            bucket      = '0;
            refill_rate = '0;
            bucket_cap  = '0;
            last_ms     = '0;
            primed      = 1'b0;
            heat_results_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (heat_results_q.size() == 0) begin
                    $error("result transaction with nothing expected: m_tdata=%h", m_tdata);
                    errs++;
                end else begin
                    want = heat_results_q.pop_front();
                    if (m_tdata[31:0] !== want.rest_heat) begin
                        $error("rest_heat mismatch: expected %h, actual %h",
                               want.rest_heat, m_tdata[31:0]);
                        errs++;
                    end
                    if (m_tdata[32] !== want.granted) begin
                        $error("granted mismatch: expected %b, actual %b",
                               want.granted, m_tdata[32]);
                        errs++;
                    end
                    if (m_tdata[33] !== want.ready_res) begin
                        $error("ready_res mismatch: expected %b, actual %b",
                               want.ready_res, m_tdata[33]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                step_budget(s_tuser, s_tdata, want);
                heat_results_q.push_back(want);
            end
            fail_count <= fail_count + errs;
            pending    <= heat_results_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Top of the heat budget token bucket testbench: clock, reset, event stimulus,
// receiver back-pressure and verdict. Depends on hbtb_pkg, the block and heat_budget_checker.
`timescale 1ns / 100ps

module tb;
    import hbtb_pkg::*;

    localparam int          N_RANDOM     = 1500;
    localparam int          CALM_TAIL    = 200;
    localparam int          HOLD_AT      = 3000;
    localparam int          HOLD_LEN     = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [2:0]  KIND_TOP     = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // now_ms, reported_heat, cooling_rate, heat_limit, heat_fresh, amount, zero
    logic [S_TDATA_W-1:0] s_tdata;
    // kind
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // rest_heat, granted, ready_res, zero
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;

    logic [31:0] clock_ms;
    logic [15:0] cur_rate;
    logic [15:0] cur_lim;
    bit          calm;

    heat_budget_token_bucket_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    heat_budget_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_event(input logic [2:0] kind, input logic [31:0] now,
                              input logic [15:0] rest, input logic [15:0] rate,
                              input logic [15:0] lim, input logic upd, input logic [23:0] amt);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, amt, upd, lim, rate, rest, now};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] pick_level(input int typical_max);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, typical_max));
        endcase
    endfunction

    task automatic next_time(output logic [31:0] now);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            clock_ms += $urandom_range(1, 40);
            now = clock_ms;
        end else if (r < 75) begin
            clock_ms += $urandom_range(41, 3000);
            now = clock_ms;
        end else if (r < 85) begin
            now = clock_ms;
        end else if (r < 93) begin
            now = clock_ms - $urandom_range(1, 100);
        end else if (r < 98) begin
            clock_ms += $urandom_range(1, 5);
            now = clock_ms;
        end else begin
            clock_ms += $urandom;
            now = clock_ms;
        end
    endtask

    task automatic random_event();
        int          sel;
        logic [31:0] now;
        logic [15:0] rest;
        logic [15:0] rate;
        logic [15:0] lim;
        logic [23:0] amt;
        logic [2:0]  kind;
        sel  = $urandom_range(0, 99);
        next_time(now);
        rate = pick_level(5000);
        lim  = pick_level(2000);
        rest = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim));
        amt  = 24'($urandom);
        if (sel < 15) begin
            kind     = KIND_RAW;
            cur_rate = rate;
            cur_lim  = lim;
        end else if (sel < 42) begin
            kind = KIND_RESERVE;
            case ($urandom_range(0, 6))
                0:       amt = '0;
                1, 2:    amt = 24'($urandom);
                default: amt = 24'($urandom_range(0, int'(cur_lim) * 64 + 1));
            endcase
        end else if (sel < 69) begin
            kind = KIND_CONSUME;
            case ($urandom_range(0, 6))
                0:       amt = '0;
                1:       amt = 24'($urandom);
                default: amt = 24'($urandom_range(0, int'(cur_rate) * 512 + 1));
            endcase
        end else if (sel < 84) begin
            kind = KIND_QUERY;
        end else if (sel < 96) begin
            kind     = KIND_RESET;
            now      = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 20);
            clock_ms = now;
            cur_rate = rate;
            cur_lim  = lim;
        end else begin
            kind = 3'($urandom_range(int'(KIND_RESET) + 1, int'(KIND_TOP)));
        end
        send_event(kind, now, rest, rate, lim, 1'($urandom), amt);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        calm     = 1'b0;
        clock_ms = '0;
        cur_rate = '0;
        cur_lim  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unprimed behavior
        send_event(KIND_CONSUME, 32'd100, 16'd0, 16'd0, 16'd0, 1'b0, 24'd500);
        send_event(KIND_RESERVE, 32'd200, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0);
        send_event(KIND_RESERVE, 32'd250, 16'd0, 16'd0, 16'd0, 1'b0, 24'd1);
        send_event(KIND_QUERY, 32'd300, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0);
        // first raw update primes, reported heat above the limit
        send_event(KIND_RAW, 32'd1000, 16'hFFFF, 16'd500, 16'd1000, 1'b1, 24'd0);
        send_event(KIND_QUERY, 32'd1000, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0);
        send_event(KIND_RAW, 32'd1500, 16'd200, 16'd400, 16'd1000, 1'b1, 24'd0);
        send_event(KIND_RAW, 32'd1600, 16'd900, 16'd400, 16'd300, 1'b0, 24'd0);
        send_event(KIND_RESERVE, 32'd1700, 16'd0, 16'd0, 16'd0, 1'b0, 24'd25600);
        send_event(KIND_RESERVE, 32'd1700, 16'd0, 16'd0, 16'd0, 1'b0, 24'hFF_FFFF);
        send_event(KIND_RESERVE, 32'd1600, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0);
        send_event(KIND_CONSUME, 32'd1700, 16'd0, 16'd0, 16'd0, 1'b0, 24'd256);
        send_event(KIND_CONSUME, 32'd1800, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0);
        send_event(KIND_CONSUME, 32'd2800, 16'd0, 16'd0, 16'd0, 1'b0, 24'd12800);
        // overdraw empties, then a consume at the same time sees an empty bucket
        send_event(KIND_CONSUME, 32'd3800, 16'd0, 16'd0, 16'd0, 1'b0, 24'hFF_FFFF);
        send_event(KIND_CONSUME, 32'd3800, 16'd0, 16'd0, 16'd0, 1'b0, 24'd1);
        // tolerance just covers the shortfall, then does not cover a larger one
        send_event(KIND_RESET, 32'd0, 16'd0, 16'd3, 16'd100, 1'b0, 24'd0);
        send_event(KIND_RESERVE, 32'd1, 16'd0, 16'd0, 16'd0, 1'b0, 24'd1);
        send_event(KIND_RESET, 32'd10, 16'd0, 16'd1, 16'd100, 1'b0, 24'd0);
        send_event(KIND_RESERVE, 32'd11, 16'd0, 16'd0, 16'd0, 1'b0, 24'd1);
        // field extremes and saturating refill
        send_event(KIND_RESET, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'hFF_FFFF);
        send_event(KIND_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'hFF_FFFF);
        send_event(KIND_RAW, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1'b1, 24'd0);
        send_event(3'(int'(KIND_RESET) + 1), 32'd5, 16'd1, 16'd1, 16'd1, 1'b1, 24'd1);
        send_event(KIND_TOP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'hFF_FFFF);

        clock_ms = 32'hFFFF_FFFF;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
            random_event();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int cyc;
        int n;
        bit held;
        cyc  = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && cyc >= HOLD_AT) begin
                held = 1'b1;
                n    = HOLD_LEN;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                m_tready <= 1'b0;
            end else begin
                n = calm ? 1 : $urandom_range(1, 20);
                m_tready <= 1'b1;
            end
            repeat (n) @(posedge aclk);
            cyc += n;
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hbtb_pkg.sv
sv/hbtb_div.sv
sv/hbtb_datapath.sv
sv/hbtb_ctrl.sv
sv/heat_budget_token_bucket_top.sv
sv/hbtb_checker.sv
verif/heat_budget_checker.sv
verif/tb.sv
